[design/star_pkg.sv]
// Package for the symmetric tensor axis rotation block.
// Holds shared types, constants and the CORDIC arctangent table; no dependencies.
package star_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned AngW   = 16;
	localparam int unsigned CoefW  = 16;
	localparam int unsigned CordW  = 28;
	localparam int unsigned AtanEntries = 24;
	localparam int unsigned AddrW  = 4;

	localparam logic [AddrW-1:0] RegAngX = 4'd0;
	localparam logic [AddrW-1:0] RegAngY = 4'd4;
	localparam logic [AddrW-1:0] RegAngZ = 4'd8;

	localparam logic signed [CordW-1:0] AngPi     = 28'sd52707179;
	localparam logic signed [CordW-1:0] AngHalfPi = 28'sd26353589;
	localparam logic signed [CordW-1:0] CordGain  = 28'sd10188014;
	localparam logic signed [CoefW-1:0] OneQ14    = 16'sd16384;

	localparam logic [1:0] AxisX = 2'd0;
	localparam logic [1:0] AxisY = 2'd1;
	localparam logic [1:0] AxisZ = 2'd2;

	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic signed [DataW-1:0] data_t;

	typedef struct packed {
		coef_t c;
		coef_t s;
		logic [1:0] axis;
	} rot_t;

	function automatic logic signed [CordW-1:0] atan_val(input logic [4:0] i);
		logic signed [CordW-1:0] v;
		case (i)
			5'd0: v = 28'sd13176795;
			5'd1: v = 28'sd7778716;
			5'd2: v = 28'sd4110060;
			5'd3: v = 28'sd2086331;
			5'd4: v = 28'sd1047214;
			5'd5: v = 28'sd524117;
			5'd6: v = 28'sd262123;
			5'd7: v = 28'sd131069;
			default: v = (i < 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
		endcase
		return v;
	endfunction

endpackage

[design/star_cordic.sv]
// Sequential CORDIC that turns a written angle into cos and sin in Q1.14.
// Depends on star_pkg.
module star_cordic #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic signed [star_pkg::AngW-1:0] ang,
	output logic                          done,
	output star_pkg::coef_t               cos_val,
	output star_pkg::coef_t               sin_val
);
	import star_pkg::*;

	localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

	logic                    run_q;
	logic [CntW-1:0]         cnt_q;
	logic signed [CordW-1:0] x_q, y_q, z_q;
	logic                    neg_q;
	logic signed [CordW-1:0] z0, xs, ys, nx, ny, nz, fx, fy;
	logic [4:0]              idx;

	function automatic coef_t to_q14(input logic signed [CordW-1:0] v);
		logic signed [CordW-1:0] r;
		r = (v + 28'sd512) >>> 10;
		if (r > 28'sd16384) r = 28'sd16384;
		if (r < -28'sd16384) r = -28'sd16384;
		return r[CoefW-1:0];
	endfunction

	assign z0  = CordW'(ang) <<< 11;
	assign idx = 5'(cnt_q);
	assign xs  = x_q >>> idx;
	assign ys  = y_q >>> idx;
	always_comb begin
		if (!z_q[CordW-1]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - atan_val(idx);
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + atan_val(idx);
		end
		fx = neg_q ? -x_q : x_q;
		fy = neg_q ? -y_q : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CntW'(CORDIC_STEPS)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= CordGain;
			y_q <= '0;
			if (z0 > AngHalfPi) begin
				z_q <= z0 - AngPi;
				neg_q <= 1'b1;
			end else if (z0 < -AngHalfPi) begin
				z_q <= z0 + AngPi;
				neg_q <= 1'b1;
			end else begin
				z_q <= z0;
				neg_q <= 1'b0;
			end
		end else if (run_q && cnt_q != CntW'(CORDIC_STEPS)) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
		if (run_q && cnt_q == CntW'(CORDIC_STEPS)) begin
			cos_val <= to_q14(fx);
			sin_val <= to_q14(fy);
		end
	end
endmodule

[design/star_regs.sv]
// APB register file for the three angles and the stored rotation.
// Depends on star_pkg and star_cordic.
module star_regs #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [star_pkg::AddrW-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           busy,
	output star_pkg::rot_t                 rot
);
	import star_pkg::*;

	logic signed [AngW-1:0] ax_q, ay_q, az_q;
	logic                   wr, hit;
	logic [1:0]             axis_next;
	logic signed [AngW-1:0] ang_next;
	logic [AngW-1:0]        wv;
	logic                   done;
	coef_t                  cv, sv;
	logic [1:0]             pend_axis_q;
	logic                   pend_q;
	logic [AddrW-1:0]       reg_addr;

	assign wr = psel && penable && pwrite;
	assign wv = pwdata[AngW-1:0];
	assign reg_addr = {paddr[AddrW-1:2], 2'b00};
	assign hit = wr && (reg_addr == RegAngX || reg_addr == RegAngY || reg_addr == RegAngZ);
	assign busy = pend_q;

	always_comb begin
		logic signed [AngW-1:0] nx, ny, nz;
		nx = ax_q;
		ny = ay_q;
		nz = az_q;
		unique case (reg_addr)
			RegAngX: nx = wv;
			RegAngY: ny = wv;
			RegAngZ: nz = wv;
			default: ;
		endcase
		if (nx != '0) begin
			axis_next = AxisX;
			ang_next  = nx;
		end else if (ny != '0) begin
			axis_next = AxisY;
			ang_next  = ny;
		end else begin
			axis_next = AxisZ;
			ang_next  = nz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			az_q <= '0;
			pend_axis_q <= AxisZ;
			pend_q <= 1'b0;
			rot <= '{c: OneQ14, s: '0, axis: AxisZ};
		end else begin
			if (hit) begin
				unique case (reg_addr)
					RegAngX: ax_q <= wv;
					RegAngY: ay_q <= wv;
					RegAngZ: az_q <= wv;
					default: ;
				endcase
				pend_axis_q <= axis_next;
			end
			if (hit) pend_q <= 1'b1;
			else if (done) pend_q <= 1'b0;
			if (done) rot <= '{c: cv, s: sv, axis: pend_axis_q};
		end
	end

	always_comb begin
		unique case (reg_addr)
			RegAngX: prdata = 32'(ax_q);
			RegAngY: prdata = 32'(ay_q);
			RegAngZ: prdata = 32'(az_q);
			default: prdata = '0;
		endcase
	end

	star_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .go(hit), .ang(ang_next),
		.done(done), .cos_val(cv), .sin_val(sv)
	);
endmodule

[design/star_pipe.sv]
// Four stage datapath computing R*T*R^T for a single-axis rotation.
// Depends on star_pkg.
module star_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  star_pkg::rot_t       rot,
	input  star_pkg::data_t      t_xx, t_yy, t_zz, t_xy, t_yz, t_xz, t_ex,
	output logic                 out_vld,
	output star_pkg::data_t      o_xx, o_yy, o_zz, o_xy, o_yz, o_xz, o_ex
);
	import star_pkg::*;

	// Permute the rotation plane into (a,b) with fixed axis f so one datapath serves all.
	// aa, bb, ab are in-plane; fa, fb couple the fixed axis; ff passes through.
	logic                 v_s1, v_s2, v_s3, v_s4;
	rot_t                 r_s1, r_s2, r_s3;
	data_t                aa_s1, bb_s1, ab_s1, fa_s1, fb_s1, ff_s1, ex_s1;
	data_t                ex_s2, ex_s3, ex_s4;
	logic signed [29:0]   cc_s2, ss_s2, cs_s2;
	data_t                aa_m_s2, bb_m_s2, ab_m_s2;
	logic signed [47:0]   fac_s2, fas_s2, fbc_s2, fbs_s2;
	data_t                ff_s2, ff_s3;
	logic signed [63:0]   paa_s3, pbb_s3, pab_s3;
	logic signed [63:0]   pfa_s3, pfb_s3;
	data_t                qa_s4, qb_s4, qab_s4, qfa_s4, qfb_s4, qff_s4;
	logic [1:0]           ax_s4;
	data_t                aa, bb, ab, fa, fb, ff;

	function automatic data_t rnd(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + 64'sd134217728) >>> 28;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	always_comb begin
		aa = t_yy; bb = t_zz; ab = t_yz; fa = t_xy; fb = t_xz; ff = t_xx;
		case (rot.axis)
			AxisX: begin
				aa = t_yy; bb = t_zz; ab = t_yz; fa = t_xy; fb = t_xz; ff = t_xx;
			end
			AxisY: begin
				aa = t_zz; bb = t_xx; ab = t_xz; fa = t_yz; fb = t_xy; ff = t_yy;
			end
			default: begin
				aa = t_xx; bb = t_yy; ab = t_xy; fa = t_xz; fb = t_yz; ff = t_zz;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_vld; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	// a' = c*a - s*b ; b' = s*a + c*b (in-plane rotation)
	always_ff @(posedge clk) begin
		r_s1 <= rot;
		aa_s1 <= aa; bb_s1 <= bb; ab_s1 <= ab;
		fa_s1 <= fa; fb_s1 <= fb; ff_s1 <= ff; ex_s1 <= t_ex;

		cc_s2 <= 30'(r_s1.c * r_s1.c);
		ss_s2 <= 30'(r_s1.s * r_s1.s);
		cs_s2 <= 30'(r_s1.c * r_s1.s);
		aa_m_s2 <= aa_s1;
		bb_m_s2 <= bb_s1;
		ab_m_s2 <= ab_s1;
		fac_s2 <= 48'(fa_s1 * r_s1.c);
		fas_s2 <= 48'(fa_s1 * r_s1.s);
		fbc_s2 <= 48'(fb_s1 * r_s1.c);
		fbs_s2 <= 48'(fb_s1 * r_s1.s);
		ff_s2 <= ff_s1; ex_s2 <= ex_s1; r_s2 <= r_s1;

		paa_s3 <= cc_s2 * aa_m_s2 + ss_s2 * bb_m_s2 - 2 * cs_s2 * ab_m_s2;
		pbb_s3 <= ss_s2 * aa_m_s2 + cc_s2 * bb_m_s2 + 2 * cs_s2 * ab_m_s2;
		pab_s3 <= cs_s2 * (aa_m_s2 - bb_m_s2) + (cc_s2 - ss_s2) * ab_m_s2;
		pfa_s3 <= (64'(fac_s2) - 64'(fbs_s2)) <<< 14;
		pfb_s3 <= (64'(fas_s2) + 64'(fbc_s2)) <<< 14;
		ff_s3 <= ff_s2; ex_s3 <= ex_s2; r_s3 <= r_s2;

		qa_s4 <= rnd(paa_s3); qb_s4 <= rnd(pbb_s3); qab_s4 <= rnd(pab_s3);
		qfa_s4 <= rnd(pfa_s3); qfb_s4 <= rnd(pfb_s3);
		qff_s4 <= rnd(64'(ff_s3) <<< 28);
		ex_s4 <= ex_s3; ax_s4 <= r_s3.axis;
	end

	always_comb begin
		o_ex = ex_s4;
		o_xx = qff_s4; o_yy = qa_s4; o_zz = qb_s4;
		o_yz = qab_s4; o_xy = qfa_s4; o_xz = qfb_s4;
		case (ax_s4)
			AxisX: begin
				o_xx = qff_s4; o_yy = qa_s4; o_zz = qb_s4;
				o_yz = qab_s4; o_xy = qfa_s4; o_xz = qfb_s4;
			end
			AxisY: begin
				o_yy = qff_s4; o_zz = qa_s4; o_xx = qb_s4;
				o_xz = qab_s4; o_yz = qfa_s4; o_xy = qfb_s4;
			end
			default: begin
				o_zz = qff_s4; o_xx = qa_s4; o_yy = qb_s4;
				o_xy = qab_s4; o_xz = qfa_s4; o_yz = qfb_s4;
			end
		endcase
	end

	assign out_vld = v_s4;
endmodule

[design/symmetric_tensor_axis_rotation_top.sv]
// Top level of the symmetric tensor axis rotation block; uses star_pkg, star_regs and star_pipe.
// A word is taken at every edge where start is high and busy is low, one per cycle, and its
// result is marked by done once it has passed the stage registers s1 to s4. The receiver cannot
// stall. An angle write holds busy high until the CORDIC is done and the matrix is rebuilt.
module symmetric_tensor_axis_rotation_top #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	output logic                       done,
	input  star_pkg::data_t            comp_xx, comp_yy, comp_zz,
	input  star_pkg::data_t            comp_xy, comp_yz, comp_xz, extra_in,
	output star_pkg::data_t            rot_xx, rot_yy, rot_zz,
	output star_pkg::data_t            rot_xy, rot_yz, rot_xz, extra_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [star_pkg::AddrW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import star_pkg::*;

	rot_t rot;

	assign pready = 1'b1;

	star_regs #(.CORDIC_STEPS(CORDIC_STEPS)) u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.busy(busy), .rot(rot)
	);

	star_pipe u_pipe (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .rot(rot),
		.t_xx(comp_xx), .t_yy(comp_yy), .t_zz(comp_zz), .t_xy(comp_xy),
		.t_yz(comp_yz), .t_xz(comp_xz), .t_ex(extra_in),
		.out_vld(done),
		.o_xx(rot_xx), .o_yy(rot_yy), .o_zz(rot_zz), .o_xy(rot_xy),
		.o_yz(rot_yz), .o_xz(rot_xz), .o_ex(extra_out)
	);

	a_ready: assert property (@(posedge clk) pready) else $error("pready low");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4)) else $error("done without start");
	a_ang: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2)
		&& $past(arst_n, 1) |-> done) else $error("lost word");
endmodule
